>>> hdl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types, codes and constants of the tick sleep queue block.
// ----------------------------------------------------------------------------
package tsq_pkg;

  // Sizes of the process table, the sleep queue and the fields.
  localparam int PROC_COUNT  = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_W       = 4;
  localparam int TIME_W      = 32;
  localparam int SLICE_W     = 16;
  localparam int UNITS_W     = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PIDX_W      = $clog2(PROC_COUNT);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd100;
  localparam logic [UNITS_W-1:0] TPU_RESET   = 16'd100;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SLEEP = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Event codes of a result item.
  typedef enum logic [1:0] {
    EV_SLEEP   = 2'd0,
    EV_WAKE    = 2'd1,
    EV_PREEMPT = 2'd2,
    EV_REJECT  = 2'd3
  } ev_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_LENGTH   = 1'b0,
    CFG_TICKS_PER_UNIT = 1'b1
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHARGE,
    S_WAKE,
    S_PREEMPT,
    S_REJECT,
    S_MUL,
    S_ADD,
    S_INSERT
  } state_t;

  // One sleep queue entry.
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] wake;
  } q_entry_t;

  // Command to the cell chain.
  typedef struct packed {
    logic insert;
    logic pop;
  } q_cmd_t;

  // Request to the per-process counters.
  typedef struct packed {
    logic              charge;
    logic              clear;
    logic [PIDX_W-1:0] idx;
  } cnt_req_t;

  // True when a pid addresses an existing process.
  function automatic logic pid_in_range(logic [PID_W-1:0] pid);
    return int'(pid) < PROC_COUNT;
  endfunction

endpackage

>>> hdl/tsq_in_if.sv
// ----------------------------------------------------------------------------
// tsq_in_if
// Input channel: valid/ready handshake with one request item.
// ----------------------------------------------------------------------------
interface tsq_in_if import tsq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [PID_W-1:0]   pid;
  logic               running_valid;
  logic [UNITS_W-1:0] sleep_units;

  modport source (output valid, operation, pid, running_valid, sleep_units, input ready);
  modport sink   (input valid, operation, pid, running_valid, sleep_units, output ready);
endinterface

>>> hdl/tsq_out_if.sv
// ----------------------------------------------------------------------------
// tsq_out_if
// Result channel: valid/ready handshake with one event item.
// ----------------------------------------------------------------------------
interface tsq_out_if import tsq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        event_res;
  logic [PID_W-1:0]  event_pid;
  logic [TIME_W-1:0] wake_time;
  logic [TIME_W-1:0] total_ticks;
  logic              last;

  modport source (output valid, event_res, event_pid, wake_time, total_ticks, last,
                  input ready);
  modport sink   (input valid, event_res, event_pid, wake_time, total_ticks, last,
                  output ready);
endinterface

>>> hdl/tsq_cell.sv
// ----------------------------------------------------------------------------
// tsq_cell
// One slot of the sorted sleep queue. It keeps its entry, shifts it to the
// right on an insert before it, and takes its right neighbor's on a pop.
// ----------------------------------------------------------------------------
module tsq_cell import tsq_pkg::*; (
  input  logic     clk,
  input  q_cmd_t   cmd,
  input  logic     occupied,
  input  q_entry_t new_ent,
  input  q_entry_t prev_ent,
  input  logic     prev_le,
  input  q_entry_t next_ent,
  output q_entry_t ent,
  output logic     le
);

  q_entry_t ent_r, ent_nxt;

  // An occupied entry due no later than the new one stays in place.
  assign le  = occupied && (ent_r.wake <= new_ent.wake);
  assign ent = ent_r;

  // Next entry: keep, take the new entry, or take the left neighbor's.
  always_comb begin
    ent_nxt = ent_r;
    if (cmd.pop) begin
      ent_nxt = next_ent;
    end else if (cmd.insert && !le) begin
      ent_nxt = prev_le ? new_ent : prev_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

>>> hdl/tsq_queue.sv
// ----------------------------------------------------------------------------
// tsq_queue
// Chain of queue cells ordered by wake time, head at cell zero.
// ----------------------------------------------------------------------------
module tsq_queue import tsq_pkg::*; (
  input  logic             clk,
  input  q_cmd_t           cmd,
  input  logic [CNT_W-1:0] count,
  input  q_entry_t         new_ent,
  output q_entry_t         head0,
  output q_entry_t         head1
);

  q_entry_t ents [QUEUE_DEPTH];
  logic     les  [QUEUE_DEPTH];

  // Each cell sees both neighbors; the head sees the new entry and a fixed flag.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tsq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occupied (CNT_W'(i) < count),
      .new_ent  (new_ent),
      .prev_ent ((i == 0) ? new_ent : ents[(i == 0) ? 0 : i - 1]),
      .prev_le  ((i == 0) ? 1'b1 : les[(i == 0) ? 0 : i - 1]),
      .next_ent ((i == QUEUE_DEPTH - 1) ? ents[i] : ents[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .ent      (ents[i]),
      .le       (les[i])
    );
  end

  assign head0 = ents[0];
  assign head1 = ents[1];

endmodule

>>> hdl/tsq_counters.sv
// ----------------------------------------------------------------------------
// tsq_counters
// Per-process slice and run-total counters with the slice expiry check.
// ----------------------------------------------------------------------------
module tsq_counters import tsq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cnt_req_t           req,
  input  logic [SLICE_W-1:0] slice_length,
  output logic               preempt,
  output logic [TIME_W-1:0]  total
);

  logic [SLICE_W-1:0] slice_r [PROC_COUNT];
  logic [TIME_W-1:0]  total_r [PROC_COUNT];
  logic               preempt_r, preempt_nxt;
  logic [TIME_W-1:0]  tot_r, tot_nxt;
  logic [SLICE_W-1:0] cnt_inc;
  logic [TIME_W-1:0]  tot_add;
  logic               expired;

  // Charge one tick and check against the slice length.
  assign cnt_inc = slice_r[req.idx] + SLICE_W'(1);
  assign tot_add = total_r[req.idx] + TIME_W'(slice_length);
  assign expired = cnt_inc >= slice_length;

  always_comb begin
    preempt_nxt = preempt_r;
    tot_nxt     = tot_r;
    if (req.charge) begin
      preempt_nxt = expired;
      tot_nxt     = tot_add;
    end
  end

  // Counter tables, cleared at reset and by a process start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PROC_COUNT; i++) begin
        slice_r[i] <= '0;
        total_r[i] <= '0;
      end
      preempt_r <= 1'b0;
    end else begin
      preempt_r <= preempt_nxt;
      if (req.clear) begin
        slice_r[req.idx] <= '0;
        total_r[req.idx] <= '0;
      end else if (req.charge) begin
        if (expired) begin
          slice_r[req.idx] <= '0;
          total_r[req.idx] <= tot_add;
        end else begin
          slice_r[req.idx] <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tot_r <= tot_nxt;
  end

  assign preempt = preempt_r;
  assign total   = tot_r;

endmodule

>>> hdl/tick_sleep_queue_with_time_slice_unit.sv
// ----------------------------------------------------------------------------
// tick_sleep_queue_with_time_slice_unit
// Tick counter, wake-time-ordered sleep queue and per-process time slices.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A start item, an unknown operation or
// an out-of-range sleep finishes in the cycle of its transfer. A sleep
// steps through multiply, add, insert into the cell chain and result; a
// rejected one goes to its result. A tick charges the running process,
// then pops one due head entry a cycle while the result port is free, and
// then sends any preemption. Sixteen queue cells each hold one entry, pass
// entries to their neighbors on insert and pop and are not cleared at
// reset. Configuration is to be written only while idle; nothing enforces it.
// ----------------------------------------------------------------------------
module tick_sleep_queue_with_time_slice_unit import tsq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tsq_in_if.sink                in_ch,
  tsq_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t             state_r, state_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SLICE_W-1:0] slice_len_r;
  logic [UNITS_W-1:0] tpu_r;
  logic [PID_W-1:0]   pid_r, pid_nxt;
  logic               run_ok_r, run_ok_nxt;
  logic [UNITS_W-1:0] units_r, units_nxt;
  logic [TIME_W-1:0]  prod_r, prod_nxt;
  logic [TIME_W-1:0]  wake_r, wake_nxt;

  logic               ovalid_r, ovalid_nxt;
  ev_t                ores_r, ores_nxt;
  logic [PID_W-1:0]   opid_r, opid_nxt;
  logic [TIME_W-1:0]  owake_r, owake_nxt;
  logic [TIME_W-1:0]  otot_r, otot_nxt;
  logic               olast_r, olast_nxt;

  q_cmd_t             q_cmd;
  q_entry_t           new_ent, head0, head1;
  cnt_req_t           cnt_req;
  logic               preempt;
  logic [TIME_W-1:0]  total;

  logic               accept, out_free, due0, due1;
  logic               charge_ok, preempt_due;
  op_t                in_op;

  assign in_op       = op_t'(in_ch.operation);
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !ovalid_r || out_ch.ready;
  assign due0        = (count_r > CNT_W'(0)) && (head0.wake <= now_r);
  assign due1        = (count_r > CNT_W'(1)) && (head1.wake <= now_r);
  assign new_ent     = '{pid: pid_r, wake: wake_r};

  // The running process of the current tick is charged only when it is valid
  // and nonzero; the slice check result counts only for such a tick.
  assign charge_ok   = run_ok_r && (pid_r != '0) && pid_in_range(pid_r);
  assign preempt_due = charge_ok && preempt;

  tsq_queue u_queue (
    .clk     (clk),
    .cmd     (q_cmd),
    .count   (count_r),
    .new_ent (new_ent),
    .head0   (head0),
    .head1   (head1)
  );

  tsq_counters u_counters (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (cnt_req),
    .slice_length (slice_len_r),
    .preempt      (preempt),
    .total        (total)
  );

  // Sequencer: next state, queue commands and result register.
  always_comb begin
    state_nxt   = state_r;
    now_nxt     = now_r;
    count_nxt   = count_r;
    pid_nxt     = pid_r;
    run_ok_nxt  = run_ok_r;
    units_nxt   = units_r;
    prod_nxt    = prod_r;
    wake_nxt    = wake_r;
    ovalid_nxt  = ovalid_r && !out_ch.ready;
    ores_nxt    = ores_r;
    opid_nxt    = opid_r;
    owake_nxt   = owake_r;
    otot_nxt    = otot_r;
    olast_nxt   = olast_r;
    q_cmd       = '0;
    cnt_req     = '{charge: 1'b0, clear: 1'b0, idx: PIDX_W'(pid_r)};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pid_nxt    = in_ch.pid;
          run_ok_nxt = in_ch.running_valid;
          units_nxt  = in_ch.sleep_units;
          unique case (in_op)
            OP_TICK: begin
              now_nxt   = now_r + TIME_W'(1);
              state_nxt = S_CHARGE;
            end
            OP_SLEEP: begin
              if (pid_in_range(in_ch.pid)) begin
                state_nxt = (count_r >= CNT_W'(QUEUE_DEPTH)) ? S_REJECT : S_MUL;
              end
            end
            OP_START: begin
              cnt_req.idx   = PIDX_W'(in_ch.pid);
              cnt_req.clear = pid_in_range(in_ch.pid);
            end
            OP_NONE: begin
            end
          endcase
        end
      end
      S_CHARGE: begin
        cnt_req.charge = charge_ok;
        state_nxt      = S_WAKE;
      end
      S_WAKE: begin
        if (due0) begin
          if (out_free) begin
            q_cmd.pop  = 1'b1;
            count_nxt  = count_r - CNT_W'(1);
            ovalid_nxt = 1'b1;
            ores_nxt   = EV_WAKE;
            opid_nxt   = head0.pid;
            owake_nxt  = head0.wake;
            otot_nxt   = '0;
            olast_nxt  = !due1 && !preempt_due;
          end
        end else begin
          state_nxt = preempt_due ? S_PREEMPT : S_IDLE;
        end
      end
      S_PREEMPT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ores_nxt   = EV_PREEMPT;
          opid_nxt   = pid_r;
          owake_nxt  = now_r;
          otot_nxt   = total;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_REJECT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ores_nxt   = EV_REJECT;
          opid_nxt   = pid_r;
          owake_nxt  = now_r;
          otot_nxt   = '0;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_MUL: begin
        prod_nxt  = TIME_W'(units_r) * TIME_W'(tpu_r);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        wake_nxt  = now_r + prod_r;
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        if (out_free) begin
          q_cmd.insert = 1'b1;
          count_nxt    = count_r + CNT_W'(1);
          ovalid_nxt   = 1'b1;
          ores_nxt     = EV_SLEEP;
          opid_nxt     = pid_r;
          owake_nxt    = wake_r;
          otot_nxt     = '0;
          olast_nxt    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      count_r     <= '0;
      ovalid_r    <= 1'b0;
      slice_len_r <= SLICE_RESET;
      tpu_r       <= TPU_RESET;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SLICE_LENGTH:   slice_len_r <= SLICE_W'(cfg_data);
          CFG_TICKS_PER_UNIT: tpu_r       <= UNITS_W'(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pid_r    <= pid_nxt;
    run_ok_r <= run_ok_nxt;
    units_r  <= units_nxt;
    prod_r   <= prod_nxt;
    wake_r   <= wake_nxt;
    ores_r   <= ores_nxt;
    opid_r   <= opid_nxt;
    owake_r  <= owake_nxt;
    otot_r   <= otot_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.event_res   = ores_r;
  assign out_ch.event_pid   = opid_r;
  assign out_ch.wake_time   = owake_r;
  assign out_ch.total_ticks = otot_r;
  assign out_ch.last        = olast_r;

  // The queue never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("sleep queue count exceeds its depth");

  // A preemption is always the final result of its tick.
  a_preempt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_res == EV_PREEMPT) |-> out_ch.last)
    else $error("preempt result not marked last");

  // A popped head leaves the count one lower.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_cmd.pop |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not decrement the queue count");

endmodule

>>> bench/tick_sleep_queue_with_time_slice_unit_tb.sv
// ----------------------------------------------------------------------------
// tick_sleep_queue_with_time_slice_unit_tb
// Self-checking bench for the tick sleep queue with time slices.
// ----------------------------------------------------------------------------
// Requests go in as timer ticks, sleep calls, process starts and unused
// codes, with random gaps on the request side and random stalls on the event
// side. A scoreboard keeps its own tick count, sorted sleep queue and
// per-process slice and run counters. From these it works out the events that
// each accepted request must produce, and checks every event transfer against
// them in order. Directed tests cover the reset register values, zero register
// values, field extremes and a full queue. Random phases under several
// register settings run before the full queue test.
// ----------------------------------------------------------------------------
module tick_sleep_queue_with_time_slice_unit_tb import tsq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 36;
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  // One expected event.
  typedef struct {
    ev_t               kind;
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] total;
    logic              last;
  } sched_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsq_in_if  in_ch ();
  tsq_out_if out_ch ();

  tick_sleep_queue_with_time_slice_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Scoreboard copy of the block state and its registers.
  logic [TIME_W-1:0]  sb_now;
  logic [PID_W-1:0]   sq_pid [QUEUE_DEPTH];
  logic [TIME_W-1:0]  sq_wake [QUEUE_DEPTH];
  int                 sq_count;
  logic [SLICE_W-1:0] slice_used [PROC_COUNT];
  logic [TIME_W-1:0]  run_total [PROC_COUNT];
  logic [SLICE_W-1:0] slice_len;
  logic [UNITS_W-1:0] tick_per_unit;

  // Events still owed by the block, oldest first.
  sched_rec_t pending_events[$];

  bit src_idle;
  bit sink_idle;
  int mismatches;
  int requests_accepted;
  int seen_by_kind [4];

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic sched_rec_t sched_rec(ev_t kind, logic [PID_W-1:0] pid,
                                           logic [TIME_W-1:0] wake,
                                           logic [TIME_W-1:0] total);
    sched_rec_t rec;
    rec.kind  = kind;
    rec.pid   = pid;
    rec.wake  = wake;
    rec.total = total;
    rec.last  = 1'b0;
    return rec;
  endfunction

  // Apply one accepted request to the scoreboard state and queue the events
  // that it causes.
  function automatic void predict_events(op_t op, logic [PID_W-1:0] pid, logic run_ok,
                                         logic [UNITS_W-1:0] units);
    sched_rec_t         batch[$];
    logic [SLICE_W-1:0] used;
    logic [TIME_W-1:0]  wake;
    int                 pos;
    int                 i;
    case (op)
      OP_TICK: begin
        sb_now = sb_now + 1;
        // Pop every head entry that is due or past.
        while (sq_count > 0 && sq_wake[0] <= sb_now) begin
          batch.push_back(sched_rec(EV_WAKE, sq_pid[0], sq_wake[0], '0));
          for (i = 1; i < sq_count; i++) begin
            sq_pid[i-1]  = sq_pid[i];
            sq_wake[i-1] = sq_wake[i];
          end
          sq_count--;
        end
        // Charge the running process and preempt it at the end of its slice.
        if (run_ok && pid != 0 && int'(pid) < PROC_COUNT) begin
          used = slice_used[pid] + 1'b1;
          if (used >= slice_len) begin
            slice_used[pid] = '0;
            run_total[pid]  = run_total[pid] + slice_len;
            batch.push_back(sched_rec(EV_PREEMPT, pid, sb_now, run_total[pid]));
          end else begin
            slice_used[pid] = used;
          end
        end
      end
      OP_SLEEP: begin
        if (int'(pid) < PROC_COUNT) begin
          if (sq_count >= QUEUE_DEPTH) begin
            batch.push_back(sched_rec(EV_REJECT, pid, sb_now, '0));
          end else begin
            wake = sb_now + units * tick_per_unit;
            // Insert after every entry due at the same time or earlier.
            pos = 0;
            while (pos < sq_count && sq_wake[pos] <= wake) pos++;
            for (i = sq_count; i > pos; i--) begin
              sq_pid[i]  = sq_pid[i-1];
              sq_wake[i] = sq_wake[i-1];
            end
            sq_pid[pos]  = pid;
            sq_wake[pos] = wake;
            sq_count++;
            batch.push_back(sched_rec(EV_SLEEP, pid, wake, '0));
          end
        end
      end
      OP_START: begin
        if (int'(pid) < PROC_COUNT) begin
          slice_used[pid] = '0;
          run_total[pid]  = '0;
        end
      end
      default: begin
      end
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) pending_events.push_back(batch[k]);
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH %s", what);
  endfunction

  // Present one request after a random gap and hold it until its transfer.
  // Valid stays high on return so that a back-to-back request needs no toggle.
  task automatic issue_request(op_t op, logic [PID_W-1:0] pid, logic run_ok,
                               logic [UNITS_W-1:0] units);
    int gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.pid           <= pid;
    in_ch.running_valid <= run_ok;
    in_ch.sleep_units   <= units;
    do @(posedge clk); while (!in_ch.ready);
    requests_accepted++;
    predict_events(op, pid, run_ok, units);
  endtask

  // Drop the request, wait for every owed event, then let a tick that wakes
  // nothing run out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SLICE_LENGTH:   slice_len     = value;
      CFG_TICKS_PER_UNIT: tick_per_unit = value;
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(logic [SLICE_W-1:0] slice, logic [UNITS_W-1:0] tpu);
    wait_idle();
    write_register(CFG_SLICE_LENGTH, slice);
    write_register(CFG_TICKS_PER_UNIT, tpu);
  endtask

  // Register values after reset: an unused code, a sleep one unit long, a zero
  // length sleep that sorts ahead of it, a start and a tick that wakes it.
  task automatic test_reset_values();
    issue_request(OP_NONE, PID_W'(6), 1'b1, 16'hFFFF);
    issue_request(OP_SLEEP, PID_W'(9), 1'b0, 16'd1);
    issue_request(OP_SLEEP, PID_W'(5), 1'b1, 16'd0);
    issue_request(OP_START, PID_W'(0), 1'b0, 16'h8001);
    issue_request(OP_TICK, PID_W'(2), 1'b1, 16'd0);
  endtask

  // Zero slice length preempts on every charged tick and adds nothing; zero
  // ticks per unit puts the wake time at the current tick.
  task automatic test_zero_registers();
    apply_setting('0, '0);
    issue_request(OP_SLEEP, PID_W'(3), 1'b1, 16'hFFFF);
    issue_request(OP_TICK, PID_W'(15), 1'b1, 16'd0);
    issue_request(OP_TICK, PID_W'(15), 1'b0, 16'd0);
    issue_request(OP_SLEEP, PID_W'(12), 1'b0, 16'h5A5A);
    issue_request(OP_TICK, PID_W'(1), 1'b1, 16'hA5A5);
  endtask

  // Fill the queue with sixteen equal wake times, get one sleep rejected, and
  // then wake all of them with a preemption on one tick.
  task automatic test_full_queue();
    int k;
    apply_setting(16'd1, 16'd1);
    while (sq_count != 0) issue_request(OP_TICK, '0, 1'b0, '0);
    for (k = 0; k < QUEUE_DEPTH; k++) issue_request(OP_SLEEP, PID_W'(k), 1'b1, 16'd2);
    issue_request(OP_SLEEP, PID_W'(7), 1'b1, 16'd3);
    issue_request(OP_TICK, PID_W'(9), 1'b1, 16'd0);
    issue_request(OP_TICK, PID_W'(9), 1'b1, 16'd0);
  endtask

  // Random mix of ticks, sleeps, starts and unused codes under one setting.
  task automatic test_random_phase(logic [SLICE_W-1:0] slice, logic [UNITS_W-1:0] tpu,
                                   bit src_on, bit sink_on);
    int                 r;
    int                 k;
    op_t                op;
    logic [UNITS_W-1:0] units;
    apply_setting(slice, tpu);
    src_idle  = src_on;
    sink_idle = sink_on;
    for (k = 0; k < PHASE_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_TICK;
      else if (r < 80) op = OP_SLEEP;
      else if (r < 93) op = OP_START;
      else op = OP_NONE;
      // Keep wake times within reach of the ticks that the run issues.
      if (tick_per_unit == 0) units = UNITS_W'($urandom);
      else if (tick_per_unit <= 3) units = UNITS_W'($urandom_range(0, 12));
      else units = '0;
      issue_request(op, PID_W'($urandom_range(0, 15)), ($urandom_range(0, 4) != 0), units);
    end
  endtask

  // Event side: random stall before each transfer, then check it.
  initial begin : event_checker
    int         stall;
    sched_rec_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = sink_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      seen_by_kind[out_ch.event_res]++;
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event res=%0d pid=%0d wake=%0d total=%0d last=%0b",
                                out_ch.event_res, out_ch.event_pid, out_ch.wake_time,
                                out_ch.total_ticks, out_ch.last));
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_res !== want.kind || out_ch.event_pid !== want.pid ||
            out_ch.wake_time !== want.wake || out_ch.total_ticks !== want.total ||
            out_ch.last !== want.last) begin
          flag_mismatch($sformatf(
            "expected res=%0d pid=%0d wake=%0d total=%0d last=%0b, got %0d %0d %0d %0d %0b",
            want.kind, want.pid, want.wake, want.total, want.last, out_ch.event_res,
            out_ch.event_pid, out_ch.wake_time, out_ch.total_ticks, out_ch.last));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_TICK;
    in_ch.pid           <= '0;
    in_ch.running_valid <= 1'b0;
    in_ch.sleep_units   <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= CFG_SLICE_LENGTH;
    cfg_data            <= '0;
    sb_now        = '0;
    sq_count      = 0;
    slice_len     = SLICE_RESET;
    tick_per_unit = TPU_RESET;
    foreach (slice_used[p]) slice_used[p] = '0;
    foreach (run_total[p]) run_total[p] = '0;
    foreach (sq_pid[q]) begin
      sq_pid[q]  = '0;
      sq_wake[q] = '0;
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_zero_registers();
    test_random_phase(16'd1, 16'd1, 1'b1, 1'b1);
    test_random_phase(16'd3, 16'd0, 1'b0, 1'b0);
    test_random_phase(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    test_random_phase(16'd5, 16'd1, 1'b0, 1'b1);
    test_random_phase(SLICE_W'($urandom_range(1, 12)), UNITS_W'($urandom_range(0, 3)),
                      1'($urandom), 1'($urandom));
    test_random_phase(SLICE_W'($urandom_range(1, 12)), UNITS_W'($urandom_range(0, 3)),
                      1'($urandom), 1'($urandom));
    test_random_phase(SLICE_W'($urandom_range(1, 12)), UNITS_W'($urandom_range(0, 3)),
                      1'b1, 1'b1);
    test_full_queue();
    wait_idle();

    $display("Ran %0d requests through reset, zero, extreme and random register settings.",
             requests_accepted);
    $display("Events checked: %0d sleeps, %0d wakes, %0d preemptions, %0d rejections.",
             seen_by_kind[EV_SLEEP], seen_by_kind[EV_WAKE], seen_by_kind[EV_PREEMPT],
             seen_by_kind[EV_REJECT]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d events still owed.", pending_events.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
